@@ sv/wsp_pkg.sv @@
// Shared types and constants of the world-to-screen projector.
package wsp_pkg;

	localparam int NUM_REGS  = 8;
	localparam int IDX_W     = 4;
	localparam int QB        = 47;
	localparam logic [31:0] DISPLAY_RESET = 32'd70780800;

	typedef enum logic [2:0] {
		REG_X_AB    = 3'd0,
		REG_X_CD    = 3'd1,
		REG_Y_AB    = 3'd2,
		REG_Y_CD    = 3'd3,
		REG_W_AB    = 3'd4,
		REG_W_CD    = 3'd5,
		REG_JITTER  = 3'd6,
		REG_DISPLAY = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic               in_front;
		logic               on_screen;
	} out_word_t;

	// control that rides along the divider stages
	typedef struct packed {
		logic valid;
		logic front;
		logic sign_x;
		logic sign_y;
		logic sat_x;
		logic sat_y;
	} div_ctl_t;

endpackage

@@ sv/world_to_screen_projector_core.sv @@
// Top level of the world-to-screen projector: register file and pipeline.
//
// Usage:
//   Input channel (in_valid/in_ready/in_word) takes one world point per word,
//   signed fixed point with FRAC_BITS fraction bits. Output channel
//   (out_valid/out_ready/out_word) returns one screen word per point, in order.
//   The config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
//   eight registers; cfg_ready is always high, indexes past the list are
//   dropped. Write config only while the pipeline is empty.
//   The pipeline runs the clip transform, a divider setup stage, 47 divider
//   stages (one quotient bit each), then the viewport map.
//   Throughput is one word per cycle when not stalled; the divider sets depth.
//   On a receiver stall the whole pipeline holds while a result waits, so
//   in_ready follows out_ready whenever the output register is full; bubbles
//   inside the pipeline do not let new words in during such a stall.
//   Reset clears all valid bits and loads the registers with their defaults
//   (zero coefficients and jitter, 1920 x 1080 display).
module world_to_screen_projector_core
	import wsp_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_word_t          in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output out_word_t         out_word,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [63:0]       cfg_data
);

	localparam int CW = 66 - FRAC_BITS;

	logic [63:0]          regs_q [NUM_REGS];
	logic [5:0][63:0]     coefs;
	logic                 adv;
	logic                 aff_valid;
	logic signed [CW-1:0] clip_x, clip_y, clip_w;
	div_ctl_t             div_ctl;
	logic [QB-1:0]        quot_x, quot_y;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
			regs_q[REG_DISPLAY] <= {32'd0, DISPLAY_RESET};
		end else if (cfg_valid && cfg_index < IDX_W'(NUM_REGS)) begin
			if (reg_idx_t'(cfg_index[2:0]) == REG_DISPLAY) begin
				regs_q[cfg_index[2:0]] <= {32'd0, cfg_data[31:0]};
			end else begin
				regs_q[cfg_index[2:0]] <= cfg_data;
			end
		end
	end

	assign cfg_ready = 1'b1;
	for (genvar k = 0; k < 6; k++) begin : g_coef
		assign coefs[k] = regs_q[k];
	end

	// global advance: hold everything while the output word is not taken
	assign adv      = out_ready || !out_valid;
	assign in_ready = adv;

	wsp_affine #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_affine (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (adv),
		.up_valid (in_valid),
		.up_word  (in_word),
		.coefs    (coefs),
		.dn_valid (aff_valid),
		.clip_x   (clip_x),
		.clip_y   (clip_y),
		.clip_w   (clip_w)
	);

	wsp_divider #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (adv),
		.up_valid (aff_valid),
		.clip_x   (clip_x),
		.clip_y   (clip_y),
		.clip_w   (clip_w),
		.dn_ctl   (div_ctl),
		.quot_x   (quot_x),
		.quot_y   (quot_y)
	);

	wsp_screen_map #(.FRAC_BITS(FRAC_BITS)) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (adv),
		.up_ctl   (div_ctl),
		.quot_x   (quot_x),
		.quot_y   (quot_y),
		.jitter   (regs_q[REG_JITTER]),
		.display  (regs_q[REG_DISPLAY][31:0]),
		.dn_valid (out_valid),
		.dn_word  (out_word)
	);

	// a point behind the viewer reports all zeros
	a_behind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.in_front |->
		out_word.screen_x == 0 && out_word.screen_y == 0 && !out_word.on_screen)
		else $error("behind point with nonzero output");

	// on screen implies in front and nonnegative coordinates
	a_onscreen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.on_screen |->
		out_word.in_front && !out_word.screen_x[31] && !out_word.screen_y[31])
		else $error("on_screen inconsistent with coordinates");

	// a stalled output word holds while input is refused
	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted during output stall");

endmodule

@@ sv/wsp_affine.sv @@
// Two-stage clip-space transform: nine products, then floored sums per axis.
module wsp_affine
	import wsp_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int CW        = 66 - FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 enable,
	input  logic                 up_valid,
	input  in_word_t             up_word,
	input  logic [5:0][63:0]     coefs,
	output logic                 dn_valid,
	output logic signed [CW-1:0] clip_x,
	output logic signed [CW-1:0] clip_y,
	output logic signed [CW-1:0] clip_w
);

	logic               valid_s1, valid_s2;
	logic signed [63:0] prod_s1 [9];
	logic signed [31:0] konst_s1 [3];
	logic signed [CW-1:0] clip_s2 [3];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (enable) begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: exact products
	always_ff @(posedge clk) begin
		if (enable) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[3*r]   <= up_word.world_x * $signed(coefs[2*r][31:0]);
				prod_s1[3*r+1] <= up_word.world_y * $signed(coefs[2*r][63:32]);
				prod_s1[3*r+2] <= up_word.world_z * $signed(coefs[2*r+1][31:0]);
				konst_s1[r]    <= $signed(coefs[2*r+1][63:32]);
			end
		end
	end

	// stage 2: floor each product to FRAC_BITS and add the constant term
	always_ff @(posedge clk) begin
		if (enable) begin
			for (int r = 0; r < 3; r++) begin
				clip_s2[r] <= CW'(prod_s1[3*r] >>> FRAC_BITS)
					+ CW'(prod_s1[3*r+1] >>> FRAC_BITS)
					+ CW'(prod_s1[3*r+2] >>> FRAC_BITS)
					+ CW'(konst_s1[r]);
			end
		end
	end

	assign dn_valid = valid_s2;
	assign clip_x   = clip_s2[0];
	assign clip_y   = clip_s2[1];
	assign clip_w   = clip_s2[2];

endmodule

@@ sv/wsp_div_step.sv @@
// One restoring division step for both clip x and clip y over a shared divisor.
module wsp_div_step
	import wsp_pkg::*;
#(
	parameter int MW = 49
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          enable,
	input  div_ctl_t      up_ctl,
	input  logic [MW-1:0] up_d,
	input  logic [MW-1:0] up_rem_x,
	input  logic [MW-1:0] up_rem_y,
	input  logic [QB-1:0] up_nq_x,
	input  logic [QB-1:0] up_nq_y,
	output div_ctl_t      dn_ctl,
	output logic [MW-1:0] dn_d,
	output logic [MW-1:0] dn_rem_x,
	output logic [MW-1:0] dn_rem_y,
	output logic [QB-1:0] dn_nq_x,
	output logic [QB-1:0] dn_nq_y
);

	logic [MW:0]   tx, ty, dd;
	logic          gx, gy;
	div_ctl_t      ctl_s1;
	logic [MW-1:0] d_s1, rem_x_s1, rem_y_s1;
	logic [QB-1:0] nq_x_s1, nq_y_s1;

	// shift in the next dividend bit and try the subtract
	always_comb begin
		dd = {1'b0, up_d};
		tx = {up_rem_x, up_nq_x[QB-1]};
		ty = {up_rem_y, up_nq_y[QB-1]};
		gx = tx >= dd;
		gy = ty >= dd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (enable) begin
			ctl_s1 <= up_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (enable) begin
			d_s1     <= up_d;
			rem_x_s1 <= gx ? MW'(tx - dd) : tx[MW-1:0];
			rem_y_s1 <= gy ? MW'(ty - dd) : ty[MW-1:0];
			nq_x_s1  <= {up_nq_x[QB-2:0], gx};
			nq_y_s1  <= {up_nq_y[QB-2:0], gy};
		end
	end

	assign dn_ctl   = ctl_s1;
	assign dn_d     = d_s1;
	assign dn_rem_x = rem_x_s1;
	assign dn_rem_y = rem_y_s1;
	assign dn_nq_x  = nq_x_s1;
	assign dn_nq_y  = nq_y_s1;

endmodule

@@ sv/wsp_divider.sv @@
// Pipelined perspective divide: setup stage, then one quotient bit per stage.
module wsp_divider
	import wsp_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int CW        = 66 - FRAC_BITS,
	parameter int MW        = CW - 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 enable,
	input  logic                 up_valid,
	input  logic signed [CW-1:0] clip_x,
	input  logic signed [CW-1:0] clip_y,
	input  logic signed [CW-1:0] clip_w,
	output div_ctl_t             dn_ctl,
	output logic [QB-1:0]        quot_x,
	output logic [QB-1:0]        quot_y
);

	localparam logic signed [CW-1:0] W_MIN = CW'((2**FRAC_BITS + 5) / 10);

	logic [CW-1:0] abs_x, abs_y;
	logic [MW-1:0] mag_x, mag_y, dv;

	div_ctl_t      ctl_s1;
	logic [MW-1:0] d_s1, rem_x_s1, rem_y_s1;
	logic [QB-1:0] nq_x_s1, nq_y_s1;

	div_ctl_t      ctl_c  [QB+1];
	logic [MW-1:0] d_c    [QB+1];
	logic [MW-1:0] rx_c   [QB+1];
	logic [MW-1:0] ry_c   [QB+1];
	logic [QB-1:0] qx_c   [QB+1];
	logic [QB-1:0] qy_c   [QB+1];

	// magnitudes and divisor
	always_comb begin
		abs_x = clip_x[CW-1] ? CW'(-clip_x) : clip_x;
		abs_y = clip_y[CW-1] ? CW'(-clip_y) : clip_y;
		mag_x = abs_x[MW-1:0];
		mag_y = abs_y[MW-1:0];
		dv    = clip_w[MW-1:0];
	end

	// setup stage: dividend bits above the quotient as starting remainder, overflow check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (enable) begin
			ctl_s1.valid  <= up_valid;
			ctl_s1.front  <= clip_w >= W_MIN;
			ctl_s1.sign_x <= clip_x[CW-1];
			ctl_s1.sign_y <= clip_y[CW-1];
			ctl_s1.sat_x  <= (mag_x >> (QB - FRAC_BITS)) >= dv;
			ctl_s1.sat_y  <= (mag_y >> (QB - FRAC_BITS)) >= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (enable) begin
			d_s1     <= dv;
			rem_x_s1 <= mag_x >> (QB - FRAC_BITS);
			rem_y_s1 <= mag_y >> (QB - FRAC_BITS);
			nq_x_s1  <= QB'({mag_x, {FRAC_BITS{1'b0}}});
			nq_y_s1  <= QB'({mag_y, {FRAC_BITS{1'b0}}});
		end
	end

	assign ctl_c[0] = ctl_s1;
	assign d_c[0]   = d_s1;
	assign rx_c[0]  = rem_x_s1;
	assign ry_c[0]  = rem_y_s1;
	assign qx_c[0]  = nq_x_s1;
	assign qy_c[0]  = nq_y_s1;

	// quotient bit chain, most significant bit first
	for (genvar i = 0; i < QB; i++) begin : g_step
		wsp_div_step #(.MW(MW)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.enable   (enable),
			.up_ctl   (ctl_c[i]),
			.up_d     (d_c[i]),
			.up_rem_x (rx_c[i]),
			.up_rem_y (ry_c[i]),
			.up_nq_x  (qx_c[i]),
			.up_nq_y  (qy_c[i]),
			.dn_ctl   (ctl_c[i+1]),
			.dn_d     (d_c[i+1]),
			.dn_rem_x (rx_c[i+1]),
			.dn_rem_y (ry_c[i+1]),
			.dn_nq_x  (qx_c[i+1]),
			.dn_nq_y  (qy_c[i+1])
		);
	end

	assign dn_ctl = ctl_c[QB];
	assign quot_x = qx_c[QB];
	assign quot_y = qy_c[QB];

endmodule

@@ sv/wsp_screen_map.sv @@
// Three-stage viewport map: jitter and bias, size multiply, saturate and edge test.
module wsp_screen_map
	import wsp_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          enable,
	input  div_ctl_t      up_ctl,
	input  logic [QB-1:0] quot_x,
	input  logic [QB-1:0] quot_y,
	input  logic [63:0]   jitter,
	input  logic [31:0]   display,
	output logic          dn_valid,
	output out_word_t     dn_word
);

	localparam int NW = QB + 3;
	localparam int PW = NW + 17;
	localparam logic [QB-1:0]        Q_LIMIT = QB'(1) << (QB - 1);
	localparam logic signed [NW-1:0] ONE_Q   = NW'(1) << FRAC_BITS;
	localparam logic signed [PW-1:0] S_MAX   = PW'($signed(32'h7FFFFFFF));
	localparam logic signed [PW-1:0] S_MIN   = PW'($signed(32'h80000000));

	logic [QB-1:0]        qcx, qcy;
	logic signed [NW-1:0] qsx, qsy, jx2, jy2;
	logic [15:0]          width, height;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 front_s1, front_s2;
	logic signed [NW-1:0] nx_s1, ny_s1;
	logic signed [PW-1:0] px_s2, py_s2;
	logic signed [PW-1:0] lim_x_s2, lim_y_s2;
	out_word_t            word_s3;

	logic signed [PW-1:0] sx, sy;

	// clamp quotients, apply sign, double jitter
	always_comb begin
		width  = display[15:0];
		height = display[31:16];
		qcx = (up_ctl.sat_x || quot_x > Q_LIMIT) ? Q_LIMIT : quot_x;
		qcy = (up_ctl.sat_y || quot_y > Q_LIMIT) ? Q_LIMIT : quot_y;
		qsx = up_ctl.sign_x ? -NW'(qcx) : NW'(qcx);
		qsy = up_ctl.sign_y ? -NW'(qcy) : NW'(qcy);
		jx2 = NW'($signed(jitter[31:0])) <<< 1;
		jy2 = NW'($signed(jitter[63:32])) <<< 1;
		sx  = px_s2 >>> 1;
		sy  = py_s2 >>> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (enable) begin
			valid_s1 <= up_ctl.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: normalized device coords biased to [0, 2]
	always_ff @(posedge clk) begin
		if (enable) begin
			front_s1 <= up_ctl.front;
			nx_s1    <= qsx + jx2 + ONE_Q;
			ny_s1    <= ONE_Q - qsy - jy2;
		end
	end

	// stage 2: scale by display size
	always_ff @(posedge clk) begin
		if (enable) begin
			front_s2 <= front_s1;
			px_s2    <= PW'(nx_s1) * PW'($signed({1'b0, width}));
			py_s2    <= PW'(ny_s1) * PW'($signed({1'b0, height}));
			lim_x_s2 <= PW'(width) << FRAC_BITS;
			lim_y_s2 <= PW'(height) << FRAC_BITS;
		end
	end

	// stage 3: halve, saturate, edge test; zeros when behind
	always_ff @(posedge clk) begin
		if (enable) begin
			if (!front_s2) begin
				word_s3 <= '0;
			end else begin
				word_s3.in_front  <= 1'b1;
				word_s3.screen_x  <= (sx > S_MAX) ? 32'sh7FFFFFFF :
					(sx < S_MIN) ? $signed(32'h80000000) : sx[31:0];
				word_s3.screen_y  <= (sy > S_MAX) ? 32'sh7FFFFFFF :
					(sy < S_MIN) ? $signed(32'h80000000) : sy[31:0];
				word_s3.on_screen <= !sx[PW-1] && sx <= lim_x_s2
					&& !sy[PW-1] && sy <= lim_y_s2;
			end
		end
	end

	assign dn_valid = valid_s3;
	assign dn_word  = word_s3;

endmodule

@@ tb/sv/world_to_screen_projector_core_tb.sv @@
// Testbench of the world-to-screen projector: directed and random points checked against a predictor.
`timescale 1ns / 100ps

module world_to_screen_projector_core_tb;
	import wsp_pkg::*;

	localparam int FRAC = 16;
	localparam longint ONE_Q = 64'sd1 <<< FRAC;
	localparam longint W_MIN = (ONE_Q + 5) / 10;
	localparam longint Q_LIMIT = 64'sd1 <<< 46;
	localparam int LATENCY = 53;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_word;
	logic out_valid;
	logic out_ready;
	out_word_t out_word;
	logic cfg_valid;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;

	// register shadow used by the predictor
	logic [63:0] shadow_regs [NUM_REGS];

	out_word_t screen_queue [$];
	int mismatches;
	int unexpected;
	bit idle_enable;
	bit hold_output;
	int hold_cycles;

	world_to_screen_projector_core #(.FRAC_BITS(FRAC)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint floor_div2n(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint half_lo(logic [63:0] r);
		return longint'(signed'(r[31:0]));
	endfunction

	function automatic longint half_hi(logic [63:0] r);
		return longint'(signed'(r[63:32]));
	endfunction

	function automatic longint clip_coord(longint x, longint y, longint z,
			logic [63:0] ab, logic [63:0] cd);
		longint acc;
		acc = floor_div2n(x * half_lo(ab), FRAC);
		acc += floor_div2n(y * half_hi(ab), FRAC);
		acc += floor_div2n(z * half_lo(cd), FRAC);
		return acc + half_hi(cd);
	endfunction

	// perspective divide, truncated toward zero and clamped
	function automatic longint persp_div(longint c, longint w);
		logic [127:0] mag;
		logic [127:0] q;
		mag = (c < 0) ? 128'(-c) : 128'(c);
		q = (mag << FRAC) / 128'(w);
		if (q > 128'(Q_LIMIT))
			q = 128'(Q_LIMIT);
		return (c < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic out_word_t project_point(in_word_t p);
		out_word_t r;
		longint cx, cy, cw, wd, ht, nx, ny, sx, sy;
		cx = clip_coord(p.world_x, p.world_y, p.world_z, shadow_regs[REG_X_AB],
			shadow_regs[REG_X_CD]);
		cy = clip_coord(p.world_x, p.world_y, p.world_z, shadow_regs[REG_Y_AB],
			shadow_regs[REG_Y_CD]);
		cw = clip_coord(p.world_x, p.world_y, p.world_z, shadow_regs[REG_W_AB],
			shadow_regs[REG_W_CD]);
		r = '0;
		if (cw < W_MIN)
			return r;
		wd = longint'(shadow_regs[REG_DISPLAY][15:0]);
		ht = longint'(shadow_regs[REG_DISPLAY][31:16]);
		nx = persp_div(cx, cw) + 2 * half_lo(shadow_regs[REG_JITTER]) + ONE_Q;
		ny = ONE_Q - persp_div(cy, cw) - 2 * half_hi(shadow_regs[REG_JITTER]);
		sx = floor_div2n(nx * wd, 1);
		sy = floor_div2n(ny * ht, 1);
		r.screen_x = sat32(sx);
		r.screen_y = sat32(sy);
		r.in_front = 1'b1;
		r.on_screen = (sx >= 0 && sx <= wd * ONE_Q && sy >= 0 && sy <= ht * ONE_Q);
		return r;
	endfunction

	// send one world point; prediction is taken at acceptance
	// valid stays up after acceptance so words can follow back to back
	task automatic send_point(in_word_t p);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_word <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		screen_queue.push_back(project_point(p));
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (screen_queue.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic write_reg(int idx, logic [63:0] val);
		cfg_index <= IDX_W'(idx);
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx >= 0 && idx < NUM_REGS)
			shadow_regs[idx] = (idx == REG_DISPLAY) ? {32'd0, val[31:0]} : val;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic in_word_t rand_point(int mode);
		in_word_t p;
		if (mode == 0) begin
			p.world_x = $urandom;
			p.world_y = $urandom;
			p.world_z = $urandom;
		end else begin
			p.world_x = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
			p.world_y = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
			p.world_z = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
		end
		return p;
	endfunction

	function automatic logic [63:0] pair(int a, int b);
		return {32'(b), 32'(a)};
	endfunction

	// camera looking along +z with moderate scale
	task automatic load_camera;
		write_reg(REG_X_AB, pair($urandom_range(0, 32'h20000), $urandom_range(0, 32'h4000)));
		write_reg(REG_X_CD, pair($urandom_range(0, 32'h4000), $urandom_range(0, 32'h10000)));
		write_reg(REG_Y_AB, pair($urandom_range(0, 32'h4000), $urandom_range(0, 32'h20000)));
		write_reg(REG_Y_CD, pair($urandom_range(0, 32'h4000), $urandom_range(0, 32'h10000)));
		write_reg(REG_W_AB, pair($urandom_range(0, 32'h1000), $urandom_range(0, 32'h1000)));
		write_reg(REG_W_CD, pair(32'h10000, $urandom_range(0, 32'h40000)));
		write_reg(REG_JITTER, pair($signed($urandom_range(0, 32'h200)) - 256,
			$signed($urandom_range(0, 32'h200)) - 256));
	endtask

	task automatic test_directed;
		in_word_t p;
		write_reg(REG_W_CD, pair(0, 32'h10000));
		write_reg(REG_X_AB, pair(32'h10000, 0));
		write_reg(REG_Y_AB, pair(0, 32'h10000));
		write_reg(9, 64'hffff_ffff_ffff_ffff);
		// centered point, edges, far off-screen and extremes
		p = '{32'sd0, 32'sd0, 32'sd0};                        send_point(p);
		p = '{32'sh10000, 32'sh10000, 32'sd0};                send_point(p);
		p = '{-32'sh10000, -32'sh10000, 32'sd0};              send_point(p);
		p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};   send_point(p);
		p = '{32'sh80000000, 32'sh80000000, 32'sh80000000};   send_point(p);
		p = '{32'sh10001, -32'sh10001, 32'sd1};               send_point(p);
		drain();
		// behind the viewer: w just under and at the threshold
		write_reg(REG_W_CD, pair(32'h10000, 0));
		p = '{32'sd0, 32'sd0, 32'(W_MIN - 1)};                send_point(p);
		p = '{32'sd0, 32'sd0, 32'(W_MIN)};                    send_point(p);
		p = '{32'sh5000, 32'sh5000, 32'(W_MIN)};              send_point(p);
		p = '{32'sd0, 32'sd0, -32'sh10000};                   send_point(p);
		drain();
		// zero-size display and max-size display, extreme coefficients
		write_reg(REG_DISPLAY, 64'hdead_beef_0000_0000);
		p = '{32'sh8000, 32'sh8000, 32'sh10000};              send_point(p);
		drain();
		write_reg(REG_DISPLAY, 64'h0000_0000_ffff_ffff);
		p = '{32'sh8000, -32'sh8000, 32'sh10000};             send_point(p);
		p = '{32'sd0, 32'sd0, 32'sh7fffffff};                 send_point(p);
		drain();
		write_reg(REG_X_CD, 64'h7fff_ffff_8000_0000);
		write_reg(REG_Y_CD, 64'h8000_0000_7fff_ffff);
		write_reg(REG_JITTER, 64'h8000_0000_7fff_ffff);
		p = '{32'sh7fffffff, 32'sh80000000, 32'sh10000};      send_point(p);
		p = '{32'sh80000000, 32'sh7fffffff, 32'sd1};          send_point(p);
		drain();
		write_reg(REG_DISPLAY, 64'd0 | DISPLAY_RESET);
	endtask

	task automatic test_random_views(int count);
		for (int k = 0; k < count; k++) begin
			if (k % 100 == 0) begin
				drain();
				if ($urandom_range(0, 3) == 0) begin
					for (int r = 0; r < NUM_REGS; r++)
						write_reg(r, {$urandom, $urandom});
				end else begin
					load_camera();
					write_reg(REG_DISPLAY, {32'd0, 16'($urandom_range(1, 2160)),
						16'($urandom_range(1, 3840))});
				end
			end
			send_point(rand_point($urandom_range(0, 4) == 0 ? 0 : 1));
		end
		drain();
	endtask

	// receiver holds off while points keep streaming in
	task automatic test_backpressure;
		drain();
		load_camera();
		hold_cycles = 120;
		hold_output = 1'b1;
		for (int k = 0; k < 100; k++)
			send_point(rand_point(1));
		wait (!hold_output);
		drain();
	endtask

	task automatic test_full_rate(int count);
		idle_enable = 1'b0;
		drain();
		load_camera();
		for (int k = 0; k < count; k++)
			send_point(rand_point(1));
		drain();
	endtask

	// receiver side: random stalls plus the long hold
	always @(negedge clk) begin
		if (hold_output) begin
			out_ready <= 1'b0;
			if (hold_cycles > 0)
				hold_cycles--;
			else
				hold_output <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 4) == 0)
			out_ready <= 1'b0;
		else
			out_ready <= 1'b1;
	end

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (screen_queue.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("unexpected result word %h", out_word);
			end else begin
				want = screen_queue.pop_front();
				if (want !== out_word) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x=%h y=%h f=%b s=%b got x=%h y=%h f=%b s=%b",
							want.screen_x, want.screen_y, want.in_front, want.on_screen,
							out_word.screen_x, out_word.screen_y, out_word.in_front,
							out_word.on_screen);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("** world_to_screen_projector_core: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		unexpected = 0;
		hold_output = 1'b0;
		hold_cycles = 0;
		idle_enable = 1'b1;
		for (int r = 0; r < NUM_REGS; r++)
			shadow_regs[r] = 64'd0;
		shadow_regs[REG_DISPLAY] = {32'd0, DISPLAY_RESET};
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_views(600);
		test_backpressure();
		test_full_rate(100);
		if (mismatches == 0 && unexpected == 0 && screen_queue.size() == 0)
			$display("** world_to_screen_projector_core: PASSED **");
		else
			$display("** world_to_screen_projector_core: FAILED **");
		$finish;
	end

endmodule
